FILE: rtl/dpo_pkg.sv
// ----------------------------------------------------------------------------
// dpo_pkg
// Shared widths, constants and the month table for the date period overlap
// pipeline.
// ----------------------------------------------------------------------------
package dpo_pkg;

  // Field widths of one request and its result.
  localparam int YEAR_W    = 14;
  localparam int MONTH_W   = 4;
  localparam int DAY_W     = 5;
  localparam int OVERLAP_W = 22;

  // A linear day number for any 14-bit year fits in 23 bits.
  localparam int DAYNUM_W  = 23;

  // Width of the days-before-month offset (at most 334).
  localparam int DBM_W     = 9;

  // Reciprocal of 25 for division by multiplication: q = (n * RECIP_25) >> RECIP_SHIFT.
  // Exact for every n below 43690, which covers every use here.
  localparam int RECIP_SHIFT = 17;
  localparam logic [12:0] RECIP_25 = 13'd5243;

  localparam logic [8:0] DAYS_PER_YEAR = 9'd365;
  localparam logic [4:0] QUOTIENT_MUL  = 5'd25;

  // Enables of the two register stages inside each day number converter.
  typedef struct packed {
    logic s1;
    logic s2;
  } stage_en_t;

  // Days in the year before the first of the given month. Month zero counts
  // as January and months above twelve count as December.
  function automatic logic [DBM_W-1:0] days_before_month(input logic [MONTH_W-1:0] month);
    logic [DBM_W-1:0] offs;
    unique case (month)
      4'd0, 4'd1: offs = 9'd0;
      4'd2:       offs = 9'd31;
      4'd3:       offs = 9'd59;
      4'd4:       offs = 9'd90;
      4'd5:       offs = 9'd120;
      4'd6:       offs = 9'd151;
      4'd7:       offs = 9'd181;
      4'd8:       offs = 9'd212;
      4'd9:       offs = 9'd243;
      4'd10:      offs = 9'd273;
      4'd11:      offs = 9'd304;
      default:    offs = 9'd334;
    endcase
    return offs;
  endfunction

endpackage

FILE: rtl/dpo_day_number.sv
// ----------------------------------------------------------------------------
// dpo_day_number
// Two-stage converter from a Gregorian year, month and day to a linear day
// number counted from the start of year zero.
// ----------------------------------------------------------------------------
module dpo_day_number (
  input  logic                           clk,
  input  dpo_pkg::stage_en_t             en,
  input  logic [dpo_pkg::YEAR_W-1:0]     year,
  input  logic [dpo_pkg::MONTH_W-1:0]    month,
  input  logic [dpo_pkg::DAY_W-1:0]      day,
  output logic [dpo_pkg::DAYNUM_W-1:0]   day_num
);

  // Stage one operands.
  logic [14:0] y99;
  logic [14:0] y399;
  logic [14:0] y3;
  logic [12:0] div100_arg;
  logic [10:0] div400_arg;
  logic [11:0] quarter;
  logic [25:0] prod100;
  logic [23:0] prod400;
  logic [24:0] prod_quarter;
  logic [dpo_pkg::DAYNUM_W-1:0] y365;

  // Stage one registers.
  logic [dpo_pkg::DAYNUM_W-1:0] y365_r;
  logic [12:0]                  q4_r;
  logic [7:0]                   q100_r;
  logic [5:0]                   q400_r;
  logic [11:0]                  quarter_r;
  logic [7:0]                   quarter_q25_r;
  logic [3:0]                   year_lo_r;
  logic [dpo_pkg::DBM_W-1:0]    dbm_r;
  logic                         after_feb_r;
  logic [dpo_pkg::DAY_W-1:0]    day_r;

  // Stage two logic and register.
  logic [11:0] quarter_rem;
  logic        leap;
  logic [dpo_pkg::DAYNUM_W-1:0] day_num_nxt;
  logic [dpo_pkg::DAYNUM_W-1:0] day_num_r;

  // Ceiling divisions are floor divisions of a biased year. Dividing by 100
  // and 400 is a shift by 2 or 4 bits followed by a multiply by 1/25.
  always_comb begin
    y99          = 15'(year) + 15'd99;
    y399         = 15'(year) + 15'd399;
    y3           = 15'(year) + 15'd3;
    div100_arg   = y99[14:2];
    div400_arg   = y399[14:4];
    quarter      = year[dpo_pkg::YEAR_W-1:2];
    prod100      = 26'(div100_arg) * 26'(dpo_pkg::RECIP_25);
    prod400      = 24'(div400_arg) * 24'(dpo_pkg::RECIP_25);
    prod_quarter = 25'(quarter) * 25'(dpo_pkg::RECIP_25);
    y365         = dpo_pkg::DAYNUM_W'(year) * dpo_pkg::DAYNUM_W'(dpo_pkg::DAYS_PER_YEAR);
  end

  // Stage one: year terms, quotients and the month offset.
  always_ff @(posedge clk) begin
    if (en.s1) begin
      y365_r        <= y365;
      q4_r          <= y3[14:2];
      q100_r        <= prod100[dpo_pkg::RECIP_SHIFT +: 8];
      q400_r        <= prod400[dpo_pkg::RECIP_SHIFT +: 6];
      quarter_r     <= quarter;
      quarter_q25_r <= prod_quarter[dpo_pkg::RECIP_SHIFT +: 8];
      year_lo_r     <= year[3:0];
      dbm_r         <= dpo_pkg::days_before_month(month);
      after_feb_r   <= (month >= 4'd3);
      day_r         <= day;
    end
  end

  // Leap year: divisible by 4, and either the quarter is not a multiple of 25
  // (so not a century) or the year is also divisible by 16 (so by 400).
  always_comb begin
    quarter_rem = quarter_r - (12'(quarter_q25_r) * 12'(dpo_pkg::QUOTIENT_MUL));
    leap        = (year_lo_r[1:0] == 2'd0) &&
                  ((quarter_rem != 12'd0) || (year_lo_r[3:2] == 2'd0));
    day_num_nxt = y365_r
                + dpo_pkg::DAYNUM_W'(q4_r)
                - dpo_pkg::DAYNUM_W'(q100_r)
                + dpo_pkg::DAYNUM_W'(q400_r)
                + dpo_pkg::DAYNUM_W'(dbm_r)
                + dpo_pkg::DAYNUM_W'(after_feb_r && leap)
                + dpo_pkg::DAYNUM_W'(day_r);
  end

  // Stage two: sum into the final day number.
  always_ff @(posedge clk) begin
    if (en.s2) begin
      day_num_r <= day_num_nxt;
    end
  end

  assign day_num = day_num_r;

endmodule

FILE: rtl/date_period_overlap_days_unit.sv
// ----------------------------------------------------------------------------
// date_period_overlap_days_unit: shared days of two Gregorian date periods.
// An accepted request passes through the two converter stages and the overlap
// stage to its result. One request is taken every cycle unless in_stall is high.
// Reset clears the stage valid bits only; the data registers are not reset.
// ----------------------------------------------------------------------------
module date_period_overlap_days_unit (
  input  logic                            clk,
  input  logic                            rst_n,

  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [dpo_pkg::YEAR_W-1:0]      in_first_start_year,
  input  logic [dpo_pkg::MONTH_W-1:0]     in_first_start_month,
  input  logic [dpo_pkg::DAY_W-1:0]       in_first_start_day,
  input  logic [dpo_pkg::YEAR_W-1:0]      in_first_end_year,
  input  logic [dpo_pkg::MONTH_W-1:0]     in_first_end_month,
  input  logic [dpo_pkg::DAY_W-1:0]       in_first_end_day,
  input  logic [dpo_pkg::YEAR_W-1:0]      in_second_start_year,
  input  logic [dpo_pkg::MONTH_W-1:0]     in_second_start_month,
  input  logic [dpo_pkg::DAY_W-1:0]       in_second_start_day,
  input  logic [dpo_pkg::YEAR_W-1:0]      in_second_end_year,
  input  logic [dpo_pkg::MONTH_W-1:0]     in_second_end_month,
  input  logic [dpo_pkg::DAY_W-1:0]       in_second_end_day,

  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [dpo_pkg::OVERLAP_W-1:0]   out_overlap_days
);

  // Stage valid bits and enables.
  logic               v1_r;
  logic               v2_r;
  logic               out_valid_r;
  logic               en1;
  logic               en2;
  logic               en3;
  dpo_pkg::stage_en_t conv_en;

  // Day numbers of the four dates.
  logic [dpo_pkg::DAYNUM_W-1:0] s1_num;
  logic [dpo_pkg::DAYNUM_W-1:0] e1_num;
  logic [dpo_pkg::DAYNUM_W-1:0] s2_num;
  logic [dpo_pkg::DAYNUM_W-1:0] e2_num;

  // Overlap stage.
  logic [dpo_pkg::DAYNUM_W-1:0]  later_start;
  logic [dpo_pkg::DAYNUM_W-1:0]  earlier_end;
  logic [dpo_pkg::DAYNUM_W-1:0]  diff;
  logic [dpo_pkg::OVERLAP_W-1:0] overlap_nxt;
  logic [dpo_pkg::OVERLAP_W-1:0] overlap_r;

  // A stage loads when it is empty or when the stage after it moves on.
  always_comb begin
    en3        = !out_valid_r || !out_stall;
    en2        = !v2_r || en3;
    en1        = !v1_r || en2;
    conv_en.s1 = en1;
    conv_en.s2 = en2;
  end

  assign in_stall = !en1;

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (en1) begin
        v1_r <= in_valid;
      end
      if (en2) begin
        v2_r <= v1_r;
      end
      if (en3) begin
        out_valid_r <= v2_r;
      end
    end
  end

  // Four converters, one for each date.
  dpo_day_number u_first_start (
    .clk     (clk),
    .en      (conv_en),
    .year    (in_first_start_year),
    .month   (in_first_start_month),
    .day     (in_first_start_day),
    .day_num (s1_num)
  );

  dpo_day_number u_first_end (
    .clk     (clk),
    .en      (conv_en),
    .year    (in_first_end_year),
    .month   (in_first_end_month),
    .day     (in_first_end_day),
    .day_num (e1_num)
  );

  dpo_day_number u_second_start (
    .clk     (clk),
    .en      (conv_en),
    .year    (in_second_start_year),
    .month   (in_second_start_month),
    .day     (in_second_start_day),
    .day_num (s2_num)
  );

  dpo_day_number u_second_end (
    .clk     (clk),
    .en      (conv_en),
    .year    (in_second_end_year),
    .month   (in_second_end_month),
    .day     (in_second_end_day),
    .day_num (e2_num)
  );

  // Later start to earlier end, zero when they do not overlap, saturated
  // to the result width.
  always_comb begin
    later_start = (s1_num > s2_num) ? s1_num : s2_num;
    earlier_end = (e1_num < e2_num) ? e1_num : e2_num;
    diff        = earlier_end - later_start;
    if (earlier_end <= later_start) begin
      overlap_nxt = '0;
    end else if (diff[dpo_pkg::DAYNUM_W-1]) begin
      overlap_nxt = '1;
    end else begin
      overlap_nxt = diff[dpo_pkg::OVERLAP_W-1:0];
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (en3) begin
      overlap_r <= overlap_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_overlap_days = overlap_r;

`ifndef SYNTHESIS
  // An accepted request always lands in the first stage.
  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> v1_r)
    else $error("accepted request did not enter stage one");

  // Back pressure reaches the input only when every stage is full.
  a_stall_only_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (v1_r && v2_r && out_valid_r && out_stall))
    else $error("input stalled while the pipeline has room");

  // A held request in stage two is not lost.
  a_stage2_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v2_r && !en3 |=> v2_r)
    else $error("stage two request dropped during a stall");

  // A taken result with nothing behind it leaves the output empty.
  a_output_drains: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_stall && !v2_r |=> !out_valid_r)
    else $error("result repeated after it was taken");
`endif

endmodule
